[rtl/volume_box_mean_filter_3x3x3_core_defines.svh]
// assertion macros for the 3x3x3 box mean filter core
// expects signals named clock and reset in the module that uses them
`ifndef VOLUME_BOX_MEAN_FILTER_3X3X3_CORE_DEFINES_SVH
`define VOLUME_BOX_MEAN_FILTER_3X3X3_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define VBMF_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define VBMF_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/vbmf_pkg.sv]
// shared types and constants for the 3x3x3 box mean filter
// no dependencies
package vbmf_pkg;

   // advance and item-present flags handed to each pipelined unit
   typedef struct packed {
      logic adv;
      logic valid;
   } pipe_ctl_type;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam int DIVISOR    = 27;
   localparam int ROUND_HALF = 13;

endpackage

[rtl/vbmf_delay_ring.sv]
// ring store giving two taps at one and two times a programmable delay
// depends on vbmf_pkg for the pipeline control struct
module vbmf_delay_ring #(
   parameter int DEPTH  = 256,
   parameter int DATA_W = 18,
   parameter int DLY_W  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vbmf_pkg::pipe_ctl_type      ctl,
   input  logic [DLY_W-1:0]            delay,
   input  logic signed [DATA_W-1:0]    wr_data,
   output logic signed [DATA_W-1:0]    tap1,
   output logic signed [DATA_W-1:0]    tap2
);
   import vbmf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] tap1_ff, tap2_ff;
   logic [AW-1:0] wp_ff, wp_in, ra1, ra2;
   logic [AW:0]   wp_x, d1_x, d2_x, a1_x, a2_x;

   always_comb begin
      wp_x = (AW+1)'(wp_ff);
      d1_x = (AW+1)'(delay);
      d2_x = (AW+1)'({delay, 1'b0});
      // modular subtract against the write pointer
      a1_x = (wp_x >= d1_x) ? (wp_x - d1_x) : (wp_x + DEPTH_X - d1_x);
      a2_x = (wp_x >= d2_x) ? (wp_x - d2_x) : (wp_x + DEPTH_X - d2_x);
      ra1  = a1_x[AW-1:0];
      ra2  = a2_x[AW-1:0];
      wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (ctl.adv && ctl.valid) begin
         wp_ff <= wp_in;
      end
   end

   // read-first: a tap at the full depth sees the entry before this write
   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         tap1_ff <= mem[ra1];
         tap2_ff <= mem[ra2];
         if (ctl.valid) begin
            mem[wp_ff] <= wr_data;
         end
      end
   end

   assign tap1 = tap1_ff;
   assign tap2 = tap2_ff;

endmodule

[rtl/vbmf_div27.sv]
// rounded signed divide by 27 using a reciprocal multiply, four stages
// depends on vbmf_pkg for the divisor, rounding offset and control struct
module vbmf_div27 #(
   parameter int SUM_W = 21,
   parameter int OUT_W = 16,
   parameter int TAG_W = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  vbmf_pkg::pipe_ctl_type     ctl,
   input  logic signed [SUM_W-1:0]    sum,
   input  logic [TAG_W-1:0]           tag_i,
   output logic                       out_valid,
   output logic signed [OUT_W-1:0]    mean,
   output logic [TAG_W-1:0]           tag_o
);
   import vbmf_pkg::*;

   localparam int MAG_W = SUM_W - 1;
   localparam int K     = MAG_W + $clog2(DIVISOR);
   localparam int M_W   = MAG_W + 1;
   localparam int P_W   = MAG_W + M_W;
   localparam logic [M_W-1:0] RECIP =
      M_W'(((longint'(1) << K) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [SUM_W-1:0] abs_v;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic neg_b_ff, neg_c_ff;
   logic [OUT_W-1:0] q, mean_in;
   logic signed [OUT_W-1:0] mean_ff;
   logic [TAG_W-1:0] tag_a_ff, tag_b_ff, tag_c_ff, tag_d_ff;

   always_comb begin
      abs_v   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mag_in  = MAG_W'(abs_v) + MAG_W'(ROUND_HALF);
      prod_in = P_W'(mag_ff) * P_W'(RECIP);
      q       = prod_ff[K +: OUT_W];
      mean_in = neg_c_ff ? (~q + OUT_W'(1)) : q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (ctl.adv) begin
         va_ff <= ctl.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         sum_ff   <= sum;
         tag_a_ff <= tag_i;
         mag_ff   <= mag_in;
         neg_b_ff <= sum_ff[SUM_W-1];
         tag_b_ff <= tag_a_ff;
         prod_ff  <= prod_in;
         neg_c_ff <= neg_b_ff;
         tag_c_ff <= tag_b_ff;
         mean_ff  <= $signed(mean_in);
         tag_d_ff <= tag_c_ff;
      end
   end

   assign out_valid = vd_ff;
   assign mean      = mean_ff;
   assign tag_o     = tag_d_ff;

endmodule

[rtl/volume_box_mean_filter_3x3x3_core.sv]
// path: an accepted voxel passes the row sum, 3x3 sum, divider and output registers
// throughput: one voxel per cycle when not stalled, set by the row and plane ring
// stores (one write, two reads per cycle); a two-deep output/skid pair absorbs rsp_stall
// reset: clears position counters, ring pointers, pipeline and output valids, and
// sets the size registers to their maxima; ring contents are not cleared
`include "volume_box_mean_filter_3x3x3_core_defines.svh"

module volume_box_mean_filter_3x3x3_core #(
   parameter int MAX_X       = 128,
   parameter int MAX_Y       = 128,
   parameter int MAX_Z       = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [$clog2(MAX_X)-1:0]             rsp_pos_x,
   output logic [$clog2(MAX_Y)-1:0]             rsp_pos_y,
   output logic [$clog2(MAX_Z)-1:0]             rsp_pos_z,
   output logic signed [SAMPLE_BITS-1:0]        rsp_mean_value,
   output logic                                 rsp_last,
   input  logic                                 csr_wen,
   input  logic [vbmf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [((($clog2(MAX_Z+1) > $clog2(MAX_X+1)) ? $clog2(MAX_Z+1)
                  : $clog2(MAX_X+1)) > $clog2(MAX_Y+1)
                 ? (($clog2(MAX_Z+1) > $clog2(MAX_X+1)) ? $clog2(MAX_Z+1)
                  : $clog2(MAX_X+1))
                 : $clog2(MAX_Y+1)) - 1:0]      csr_wdata
);
   import vbmf_pkg::*;

   localparam int X_W   = $clog2(MAX_X);
   localparam int Y_W   = $clog2(MAX_Y);
   localparam int Z_W   = $clog2(MAX_Z);
   localparam int XS_W  = $clog2(MAX_X + 1);
   localparam int YS_W  = $clog2(MAX_Y + 1);
   localparam int ZS_W  = $clog2(MAX_Z + 1);
   localparam int PL_W  = $clog2(MAX_X * MAX_Y + 1);
   localparam int R_W   = SAMPLE_BITS + 2;
   localparam int C_W   = SAMPLE_BITS + 4;
   localparam int S_W   = SAMPLE_BITS + 5;
   localparam int TAG_W = X_W + Y_W + Z_W + 1;
   localparam int CNT_W = X_W + Y_W + Z_W;

   // configuration
   logic [XS_W-1:0] size_x_ff, sx_c;
   logic [YS_W-1:0] size_y_ff, sy_c;
   logic [ZS_W-1:0] size_z_ff, sz_c;
   logic [PL_W-1:0] plane_len_ff;
   logic [XS_W+YS_W-1:0] plane_len_in;

   // position counters
   logic [X_W-1:0] col_ff;
   logic [Y_W-1:0] row_ff;
   logic [Z_W-1:0] plane_ff;
   logic [X_W:0]   x_next;
   logic [Y_W:0]   y_next;
   logic [Z_W:0]   z_next;
   logic x_end, y_end, z_end, emit_in, last_in;
   logic [TAG_W-1:0] tag_in;
   logic [CNT_W-1:0] cnt_all;

   // pipeline
   logic adv, accept;
   logic signed [SAMPLE_BITS-1:0] hist1_ff, hist2_ff;
   logic signed [R_W-1:0] r_in, r1_ff, r2_ff, row_t1, row_t2;
   logic signed [C_W-1:0] c2, c3_ff, pl_t1, pl_t2;
   logic signed [S_W-1:0] sum3;
   logic v1_ff, v2_ff, v3_ff, emit1_ff, emit2_ff;
   logic [TAG_W-1:0] tag1_ff, tag2_ff, tag3_ff;
   pipe_ctl_type row_ctl, plane_ctl, div_ctl;

   // divider result and output stage
   logic d_valid;
   logic signed [SAMPLE_BITS-1:0] d_mean;
   logic [TAG_W-1:0] d_tag;
   logic out_valid_ff, skid_valid_ff, take, new_res;
   logic signed [SAMPLE_BITS-1:0] out_mean_ff, skid_mean_ff;
   logic [TAG_W-1:0] out_tag_ff, skid_tag_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= XS_W'(MAX_X);
         size_y_ff <= YS_W'(MAX_Y);
         size_z_ff <= ZS_W'(MAX_Z);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata[XS_W-1:0];
            CSR_SIZE_Y: size_y_ff <= csr_wdata[YS_W-1:0];
            CSR_SIZE_Z: size_z_ff <= csr_wdata[ZS_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      sx_c = (size_x_ff == '0) ? XS_W'(1) :
             (size_x_ff > XS_W'(MAX_X)) ? XS_W'(MAX_X) : size_x_ff;
      sy_c = (size_y_ff == '0) ? YS_W'(1) :
             (size_y_ff > YS_W'(MAX_Y)) ? YS_W'(MAX_Y) : size_y_ff;
      sz_c = (size_z_ff == '0) ? ZS_W'(1) :
             (size_z_ff > ZS_W'(MAX_Z)) ? ZS_W'(MAX_Z) : size_z_ff;
      plane_len_in = (XS_W+YS_W)'(sx_c) * (XS_W+YS_W)'(sy_c);
   end

   always_ff @(posedge clock) begin
      plane_len_ff <= plane_len_in[PL_W-1:0];
   end

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      x_next  = (X_W+1)'(col_ff) + (X_W+1)'(1);
      y_next  = (Y_W+1)'(row_ff) + (Y_W+1)'(1);
      z_next  = (Z_W+1)'(plane_ff) + (Z_W+1)'(1);
      x_end   = x_next >= (X_W+1)'(sx_c);
      y_end   = y_next >= (Y_W+1)'(sy_c);
      z_end   = z_next >= (Z_W+1)'(sz_c);
      emit_in = (col_ff >= X_W'(2)) && (row_ff >= Y_W'(2)) && (plane_ff >= Z_W'(2));
      last_in = (x_next == (X_W+1)'(sx_c)) && (y_next == (Y_W+1)'(sy_c)) &&
                (z_next == (Z_W+1)'(sz_c));
      tag_in  = {col_ff - X_W'(1), row_ff - Y_W'(1), plane_ff - Z_W'(1), last_in};
      r_in    = R_W'(req_sample) + R_W'(hist1_ff) + R_W'(hist2_ff);
      cnt_all = {col_ff, row_ff, plane_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         plane_ff <= '0;
      end else if (accept) begin
         if (x_end) begin
            col_ff <= '0;
            if (y_end) begin
               row_ff <= '0;
               plane_ff <= z_end ? '0 : z_next[Z_W-1:0];
            end else begin
               row_ff <= y_next[Y_W-1:0];
            end
         end else begin
            col_ff <= x_next[X_W-1:0];
         end
      end
   end

   // x taps of the window: the two previous samples
   always_ff @(posedge clock) begin
      if (accept) begin
         hist1_ff <= req_sample;
         hist2_ff <= hist1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         emit1_ff <= 1'b0;
         emit2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= accept;
         emit1_ff <= accept && emit_in;
         v2_ff    <= v1_ff;
         emit2_ff <= emit1_ff;
         v3_ff    <= v2_ff && emit2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff   <= r_in;
         tag1_ff <= tag_in;
         r2_ff   <= r1_ff;
         tag2_ff <= tag1_ff;
         c3_ff   <= c2;
         tag3_ff <= tag2_ff;
      end
   end

   // y taps: row sums one and two rows back
   assign row_ctl = '{adv: adv, valid: v1_ff};

   vbmf_delay_ring #(
      .DEPTH  (2 * MAX_X),
      .DATA_W (R_W),
      .DLY_W  (XS_W)
   ) u_row_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (row_ctl),
      .delay   (sx_c),
      .wr_data (r1_ff),
      .tap1    (row_t1),
      .tap2    (row_t2)
   );

   assign c2 = C_W'(r2_ff) + C_W'(row_t1) + C_W'(row_t2);

   // z taps: 3x3 sums one and two planes back
   assign plane_ctl = '{adv: adv, valid: v2_ff};

   vbmf_delay_ring #(
      .DEPTH  (2 * MAX_X * MAX_Y),
      .DATA_W (C_W),
      .DLY_W  (PL_W)
   ) u_plane_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (plane_ctl),
      .delay   (plane_len_ff),
      .wr_data (c2),
      .tap1    (pl_t1),
      .tap2    (pl_t2)
   );

   assign sum3    = S_W'(c3_ff) + S_W'(pl_t1) + S_W'(pl_t2);
   assign div_ctl = '{adv: adv, valid: v3_ff};

   vbmf_div27 #(
      .SUM_W (S_W),
      .OUT_W (SAMPLE_BITS),
      .TAG_W (TAG_W)
   ) u_div27 (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .sum       (sum3),
      .tag_i     (tag3_ff),
      .out_valid (d_valid),
      .mean      (d_mean),
      .tag_o     (d_tag)
   );

   // output register with skid stage behind it
   assign take    = out_valid_ff && !rsp_stall;
   assign new_res = adv && d_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         out_valid_ff  <= skid_valid_ff || new_res;
         skid_valid_ff <= 1'b0;
      end else if (new_res) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_mean_ff <= skid_valid_ff ? skid_mean_ff : d_mean;
         out_tag_ff  <= skid_valid_ff ? skid_tag_ff : d_tag;
      end else if (new_res) begin
         skid_mean_ff <= d_mean;
         skid_tag_ff  <= d_tag;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_mean_value = out_mean_ff;
   assign rsp_pos_x      = out_tag_ff[TAG_W-1 -: X_W];
   assign rsp_pos_y      = out_tag_ff[TAG_W-1-X_W -: Y_W];
   assign rsp_pos_z      = out_tag_ff[Z_W:1];
   assign rsp_last       = out_tag_ff[0];

   `VBMF_CHECK_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid holds data with output empty")
   `VBMF_CHECK_NOW(a_skid_fill, $rose(skid_valid_ff), $past(out_valid_ff && rsp_stall), "skid filled without a stalled output")
   `VBMF_CHECK_NEXT(a_cnt_hold, !accept, $stable(cnt_all), "position moved without a transaction")

endmodule
